// File: hdl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on clk, off while rst_n is low.
`define DRST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication.
`define DRST_ASSERT_IMPL(label, ante, cons, msg) \
  `DRST_ASSERT(label, (ante) |-> (cons), msg)

`endif

// File: hdl/drst_pkg.sv
package drst_pkg;

  typedef enum logic [1:0] {
    FUNC_TOUCH   = 2'd0,
    FUNC_CLEAR   = 2'd1,
    FUNC_OFFER   = 2'd2,
    FUNC_REGIONS = 2'd3
  } func_t;

  // Datapath work selected by the controller.
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_INIT,
    OP_CLEAR,
    OP_TOUCH,
    OP_OFFER,
    OP_SCAN,
    OP_FIN
  } op_t;

  localparam logic [6:0] MaxRegions = 7'd64;

  typedef struct packed {
    func_t      func;
    logic [8:0] rect_left;
    logic [8:0] rect_top;
    logic [8:0] rect_right;
    logic [8:0] rect_bottom;
    logic [6:0] region_cap;
  } in_item_t;

  typedef struct packed {
    logic       region_valid;
    logic [8:0] region_x;
    logic [8:0] region_y;
    logic [8:0] region_w;
    logic [8:0] region_h;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [8:0] left;
    logic [8:0] right;
  } span_t;

  typedef struct packed {
    logic load;
    op_t  mode;
  } drst_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic scan_done;
  } drst_sts_t;

endpackage

// File: hdl/drst_ctrl.sv
module drst_ctrl import drst_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  func_t     func,
  input  drst_sts_t sts,
  output logic      busy,
  output drst_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_WALK,
    ST_SCAN,
    ST_FIN
  } state_t;

  state_t state_r;
  op_t    mode_r;
  logic   busy_r;
  logic   load;

  assign load     = start && !busy_r;
  assign busy     = busy_r;
  assign cmd.load = load;
  assign cmd.mode = mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      mode_r  <= OP_INIT;
      busy_r  <= 1'b1;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (load) begin
            busy_r <= 1'b1;
            unique case (func)
              FUNC_TOUCH: begin
                state_r <= ST_WALK;
                mode_r  <= OP_TOUCH;
              end
              FUNC_CLEAR: begin
                state_r <= ST_WALK;
                mode_r  <= OP_CLEAR;
              end
              FUNC_OFFER: begin
                state_r <= ST_WALK;
                mode_r  <= OP_OFFER;
              end
              FUNC_REGIONS: begin
                state_r <= ST_SCAN;
                mode_r  <= OP_SCAN;
              end
              default: begin
                state_r <= ST_IDLE;
                mode_r  <= OP_IDLE;
                busy_r  <= 1'b0;
              end
            endcase
          end
        end
        ST_INIT, ST_WALK: begin
          if (sts.walk_done) begin
            state_r <= ST_IDLE;
            mode_r  <= OP_IDLE;
            busy_r  <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (sts.scan_done) begin
            state_r <= ST_FIN;
            mode_r  <= OP_FIN;
          end
        end
        ST_FIN: begin
          state_r <= ST_IDLE;
          mode_r  <= OP_IDLE;
          busy_r  <= 1'b0;
        end
        default: begin
          state_r <= ST_IDLE;
          mode_r  <= OP_IDLE;
          busy_r  <= 1'b0;
        end
      endcase
    end
  end

endmodule

// File: hdl/drst_dp.sv
module drst_dp import drst_pkg::*; #(
  parameter int WIDTH  = 320,
  parameter int HEIGHT = 480
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  drst_cmd_t cmd,
  output drst_sts_t sts,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int RowW = $clog2(HEIGHT + 1);
  localparam int AddrW = $clog2(HEIGHT);
  localparam logic [RowW-1:0] RowEnd = RowW'(HEIGHT);
  localparam logic [8:0] HeightV = 9'(HEIGHT);
  localparam span_t EmptySpan = '{left: 9'(WIDTH), right: 9'd0};

  span_t live_mem [HEIGHT];
  span_t snap_mem [HEIGHT];
  span_t live_q_r;
  span_t snap_q_r;

  in_item_t        req_r;
  logic [6:0]      cap_r;
  logic [RowW-1:0] row_r;
  logic [RowW-1:0] end_r;
  logic [RowW-1:0] data_row_r;
  logic            data_vld_r;
  logic            stop_r;
  logic            in_run_r;
  logic [8:0]      run_l_r;
  logic [8:0]      run_rt_r;
  logic [RowW-1:0] run_top_r;
  out_item_t       pend_r;
  logic            have_pend_r;
  logic [6:0]      cnt_r;
  logic            out_valid_r;
  out_item_t       out_r;

  logic [8:0]      touch_end9;
  logic [RowW-1:0] touch_end;
  logic [RowW-1:0] start_row;
  logic [6:0]      cap_eff;
  logic            row_left;
  logic            issue_rd;
  logic            direct_wr;
  logic            live_we;
  logic [AddrW-1:0] live_wa;
  span_t           live_wd;
  logic            snap_we;
  logic [AddrW-1:0] snap_wa;
  span_t           snap_wd;
  span_t           merged;
  logic            dirty;
  logic            scan_act;
  logic            close_now;
  logic            end_now;
  logic [RowW-1:0] close_row;
  logic [6:0]      cnt_inc;
  out_item_t       new_region;

  always_comb begin
    touch_end9 = (in_item.rect_bottom > HeightV) ? HeightV : in_item.rect_bottom;
    touch_end  = RowW'(touch_end9);
    start_row  = (in_item.rect_top < touch_end9) ? RowW'(in_item.rect_top) : touch_end;
    if (in_item.region_cap == 7'd0) begin
      cap_eff = 7'd1;
    end else if (in_item.region_cap > MaxRegions) begin
      cap_eff = MaxRegions;
    end else begin
      cap_eff = in_item.region_cap;
    end
  end

  always_comb begin
    row_left  = row_r < end_r;
    issue_rd  = row_left && ((cmd.mode == OP_TOUCH) || (cmd.mode == OP_OFFER) ||
                             ((cmd.mode == OP_SCAN) && !stop_r));
    direct_wr = row_left && ((cmd.mode == OP_INIT) || (cmd.mode == OP_CLEAR));

    merged.left  = (req_r.rect_left < live_q_r.left) ? req_r.rect_left : live_q_r.left;
    merged.right = (req_r.rect_right > live_q_r.right) ? req_r.rect_right : live_q_r.right;

    live_we = direct_wr || ((cmd.mode == OP_TOUCH) && data_vld_r);
    live_wa = direct_wr ? row_r[AddrW-1:0] : data_row_r[AddrW-1:0];
    live_wd = direct_wr ? EmptySpan : merged;

    snap_we = ((cmd.mode == OP_INIT) && direct_wr) || ((cmd.mode == OP_OFFER) && data_vld_r);
    snap_wa = direct_wr ? row_r[AddrW-1:0] : data_row_r[AddrW-1:0];
    snap_wd = direct_wr ? EmptySpan : live_q_r;
  end

  // Region merge: a run closes on the first clean row, or when the walk runs out.
  always_comb begin
    dirty     = snap_q_r.right > snap_q_r.left;
    scan_act  = (cmd.mode == OP_SCAN) && !stop_r;
    end_now   = scan_act && !data_vld_r && (row_r == end_r);
    close_now = scan_act && in_run_r && ((data_vld_r && !dirty) || end_now);
    close_row = data_vld_r ? data_row_r : end_r;
    cnt_inc   = cnt_r + 7'd1;

    new_region.region_valid = 1'b1;
    new_region.region_x     = run_l_r;
    new_region.region_y     = 9'(run_top_r);
    new_region.region_w     = run_rt_r - run_l_r;
    new_region.region_h     = 9'(close_row - run_top_r);
    new_region.last         = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      end_r       <= RowEnd;
      data_vld_r  <= 1'b0;
      stop_r      <= 1'b0;
      in_run_r    <= 1'b0;
      have_pend_r <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      data_vld_r  <= issue_rd;
      out_valid_r <= 1'b0;
      if (cmd.load) begin
        row_r       <= (in_item.func == FUNC_TOUCH) ? start_row : '0;
        end_r       <= (in_item.func == FUNC_TOUCH) ? touch_end : RowEnd;
        stop_r      <= 1'b0;
        in_run_r    <= 1'b0;
        have_pend_r <= 1'b0;
        cnt_r       <= '0;
      end else begin
        if (issue_rd || direct_wr) begin
          row_r <= row_r + 1'b1;
        end
        if (scan_act && data_vld_r && dirty) begin
          in_run_r <= 1'b1;
        end
        if (close_now) begin
          in_run_r    <= 1'b0;
          have_pend_r <= 1'b1;
          cnt_r       <= cnt_inc;
          if (have_pend_r) begin
            out_valid_r <= 1'b1;
          end
          if (cnt_inc == cap_r) begin
            stop_r <= 1'b1;
          end
        end
        if (end_now) begin
          stop_r <= 1'b1;
        end
        if (cmd.mode == OP_FIN) begin
          out_valid_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (live_we) begin
      live_mem[live_wa] <= live_wd;
    end
    if (snap_we) begin
      snap_mem[snap_wa] <= snap_wd;
    end
    if (issue_rd) begin
      live_q_r <= live_mem[row_r[AddrW-1:0]];
      snap_q_r <= snap_mem[row_r[AddrW-1:0]];
    end
    data_row_r <= row_r;
    if (cmd.load) begin
      req_r <= in_item;
      cap_r <= cap_eff;
    end
    if (scan_act && data_vld_r && dirty) begin
      if (!in_run_r) begin
        run_l_r   <= snap_q_r.left;
        run_rt_r  <= snap_q_r.right;
        run_top_r <= data_row_r;
      end else begin
        if (snap_q_r.left < run_l_r) begin
          run_l_r <= snap_q_r.left;
        end
        if (snap_q_r.right > run_rt_r) begin
          run_rt_r <= snap_q_r.right;
        end
      end
    end
    // A finished region is held back one step so the final one can carry last.
    if (close_now) begin
      pend_r <= new_region;
      if (have_pend_r) begin
        out_r <= pend_r;
      end
    end
    if (cmd.mode == OP_FIN) begin
      if (have_pend_r) begin
        out_r      <= pend_r;
        out_r.last <= 1'b1;
      end else begin
        out_r      <= '0;
        out_r.last <= 1'b1;
      end
    end
  end

  assign sts.walk_done = (row_r == end_r) && !data_vld_r;
  assign sts.scan_done = stop_r;
  assign out_valid     = out_valid_r;
  assign out_item      = out_r;

endmodule

// File: hdl/dirty_row_span_tracker_unit.sv
// Dirty row span tracker: one dirty span per display row plus a snapshot.
// Request channel: drive in_item and raise start; the request is taken at the
// rising edge where start is high and busy is low. busy stays high until the
// request has finished its walk over the rows.
// Touch walks the rows of its rectangle once, and walks none when the clamped
// rectangle covers no row. Clear writes all HEIGHT rows. Offer reads and
// writes all rows. A regions request reads the snapshot one row per cycle and
// stops early when the cap is reached. The walks are set by the single read
// port of each span memory, one row per cycle.
// Result channel: out_valid marks one result for one cycle on out_item. Only a
// regions request produces results (one to 64), the final one with last set;
// results come out in row order, at most one per cycle. The receiver cannot
// stall; every result is shown once and is gone in the next cycle.
// Reset (rst_n low, synchronous) starts a clearing pass that writes both span
// memories to empty, one row per cycle; busy is high until it is done.
module dirty_row_span_tracker_unit import drst_pkg::*; #(
  parameter int WIDTH  = 320,
  parameter int HEIGHT = 480
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  drst_cmd_t cmd;
  drst_sts_t sts;

  drst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .func  (in_item.func),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  drst_dp #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// File: hdl/drst_chk.sv
`include "assert_macros.svh"

module drst_chk import drst_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_item,
  input logic      out_valid,
  input out_item_t out_item
);

  // An empty answer is always a single, final result.
  `DRST_ASSERT_IMPL(a_empty_is_last, out_valid && !out_item.region_valid, out_item.last, "empty result without last")

  `DRST_ASSERT_IMPL(a_empty_is_zero, out_valid && !out_item.region_valid, (out_item.region_x == 9'd0) && (out_item.region_y == 9'd0) && (out_item.region_w == 9'd0) && (out_item.region_h == 9'd0), "empty result with nonzero fields")

  // A merged region covers at least one dirty row of nonzero width.
  `DRST_ASSERT_IMPL(a_region_size, out_valid && out_item.region_valid, (out_item.region_w != 9'd0) && (out_item.region_h != 9'd0), "region of zero size")

  // Results only follow a cycle in which a request was in work.
  `DRST_ASSERT_IMPL(a_result_in_work, out_valid, $past(busy), "result without a request in work")

endmodule

bind dirty_row_span_tracker_unit drst_chk u_drst_chk (.*);

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import drst_pkg::*;

  localparam int COLS = 320;
  localparam int ROWS = 480;
  localparam int STALL_LIMIT = 4000;
  localparam int TARGET_REQS = 170;

  typedef struct {
    bit       drain;
    in_item_t req;
  } pending_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  // Model copy of the span memories.
  logic [8:0] live_lft [ROWS];
  logic [8:0] live_rgt [ROWS];
  logic [8:0] snap_lft [ROWS];
  logic [8:0] snap_rgt [ROWS];

  pending_t  pending_q[$];
  out_item_t region_q[$];

  int queued_cnt = 0;
  int accepted_cnt = 0;
  int err_cnt = 0;
  int touch_cnt = 0;
  int clear_cnt = 0;
  int offer_cnt = 0;
  int scan_cnt = 0;
  int region_cnt = 0;
  int empty_cnt = 0;
  int gap_left = 0;
  int idle_cycles = 0;
  bit bursting = 1'b0;

  dirty_row_span_tracker_unit #(
    .WIDTH (COLS),
    .HEIGHT(ROWS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  task automatic note_error(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic cmp_field(input string name, input logic [8:0] got, input logic [8:0] want);
    if (got !== want)
      note_error($sformatf("region field %s: got %0d, expected %0d", name, got, want));
  endtask

  task automatic empty_spans();
    for (int r = 0; r < ROWS; r++) begin
      live_lft[r] = COLS[8:0];
      live_rgt[r] = '0;
    end
  endtask

  // Works out the regions that the snapshot yields, in row order.
  task automatic scan_snapshot(input logic [6:0] cap_field);
    out_item_t found[$];
    out_item_t one;
    int cap;
    int row;
    int top;
    logic [8:0] lo;
    logic [8:0] hi;

    cap = cap_field;
    if (cap == 0) cap = 1;
    if (cap > MaxRegions) cap = MaxRegions;
    row = 0;
    while (row < ROWS && found.size() < cap) begin
      if (!(snap_rgt[row] > snap_lft[row])) begin
        row++;
        continue;
      end
      lo = snap_lft[row];
      hi = snap_rgt[row];
      top = row;
      while (row < ROWS && snap_rgt[row] > snap_lft[row]) begin
        if (snap_lft[row] < lo) lo = snap_lft[row];
        if (snap_rgt[row] > hi) hi = snap_rgt[row];
        row++;
      end
      one = '0;
      one.region_valid = 1'b1;
      one.region_x = lo;
      one.region_y = top[8:0];
      one.region_w = hi - lo;
      one.region_h = 9'(row - top);
      found.push_back(one);
    end
    if (found.size() == 0) begin
      one = '0;
      one.last = 1'b1;
      found.push_back(one);
    end else begin
      found[found.size() - 1].last = 1'b1;
    end
    foreach (found[i]) region_q.push_back(found[i]);
  endtask

  task automatic predict_request(input in_item_t r);
    int bot;
    case (r.func)
      FUNC_TOUCH: begin
        touch_cnt++;
        bot = (r.rect_bottom > ROWS) ? ROWS : r.rect_bottom;
        for (int row = r.rect_top; row < bot; row++) begin
          if (r.rect_left < live_lft[row]) live_lft[row] = r.rect_left;
          if (r.rect_right > live_rgt[row]) live_rgt[row] = r.rect_right;
        end
      end
      FUNC_CLEAR: begin
        clear_cnt++;
        empty_spans();
      end
      FUNC_OFFER: begin
        offer_cnt++;
        for (int row = 0; row < ROWS; row++) begin
          snap_lft[row] = live_lft[row];
          snap_rgt[row] = live_rgt[row];
        end
      end
      default: begin
        scan_cnt++;
        scan_snapshot(r.region_cap);
      end
    endcase
  endtask

  task automatic queue_req(input func_t f, input int lft, input int top, input int rgt,
                           input int bot, input int cap);
    pending_t p;
    p.drain = 1'b0;
    p.req.func = f;
    p.req.rect_left = lft[8:0];
    p.req.rect_top = top[8:0];
    p.req.rect_right = rgt[8:0];
    p.req.rect_bottom = bot[8:0];
    p.req.region_cap = cap[6:0];
    pending_q.push_back(p);
    queued_cnt++;
  endtask

  task automatic queue_drain();
    pending_t p;
    p.drain = 1'b1;
    p.req = '0;
    pending_q.push_back(p);
  endtask

  task automatic queue_other(input func_t f, input int cap);
    queue_req(f, $urandom_range(0, 511), $urandom_range(0, 511), $urandom_range(0, 511),
              $urandom_range(0, 511), cap);
  endtask

  task automatic queue_touch();
    int top;
    int bot;
    int lft;
    int rgt;
    top = $urandom_range(0, ROWS - 1);
    if ($urandom_range(0, 9) == 0) bot = $urandom_range(0, 511);
    else bot = top + $urandom_range(1, 24);
    if (bot > 511) bot = 511;
    if ($urandom_range(0, 9) == 0) begin
      lft = $urandom_range(0, 511);
      rgt = $urandom_range(0, 511);
    end else begin
      lft = $urandom_range(0, COLS - 1);
      rgt = $urandom_range(lft + 1, COLS);
    end
    queue_req(FUNC_TOUCH, lft, top, rgt, bot, $urandom_range(0, 127));
  endtask

  function automatic int pick_cap();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return $urandom_range(MaxRegions + 1, 127);
      2, 3, 4: return $urandom_range(1, 3);
      default: return $urandom_range(1, MaxRegions);
    endcase
  endfunction

  task automatic queue_frame();
    if ($urandom_range(0, 2) == 0) queue_other(FUNC_CLEAR, $urandom_range(0, 127));
    repeat ($urandom_range(1, 8)) queue_touch();
    if ($urandom_range(0, 5) == 0) begin
      queue_other(func_t'($urandom_range(0, 3)), $urandom_range(0, 127));
    end
    // A frame left without an offer scans the previous snapshot again.
    if ($urandom_range(0, 7) != 0) queue_other(FUNC_OFFER, $urandom_range(0, 127));
    queue_other(FUNC_REGIONS, pick_cap());
    if ($urandom_range(0, 2) == 0) queue_other(FUNC_REGIONS, pick_cap());
  endtask

  always @(posedge clk) begin : driver
    pending_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) begin
        predict_request(in_item);
        accepted_cnt++;
        if ($urandom_range(0, 15) == 0) bursting = !bursting;
        gap_left = bursting ? 0 : $urandom_range(0, 4);
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_q.size() > 0 && pending_q[0].drain) begin
        if (region_q.size() == 0) nxt = pending_q.pop_front();
        start <= 1'b0;
      end else if (pending_q.size() > 0) begin
        nxt = pending_q.pop_front();
        in_item <= nxt.req;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n && out_valid) begin
      if (region_q.size() == 0) begin
        note_error($sformatf("result %h with no regions request outstanding", out_item));
      end else begin
        want = region_q.pop_front();
        cmp_field("region_valid", 9'(out_item.region_valid), 9'(want.region_valid));
        cmp_field("region_x", out_item.region_x, want.region_x);
        cmp_field("region_y", out_item.region_y, want.region_y);
        cmp_field("region_w", out_item.region_w, want.region_w);
        cmp_field("region_h", out_item.region_h, want.region_h);
        cmp_field("last", 9'(out_item.last), 9'(want.last));
        if (want.region_valid) region_cnt++;
        else empty_cnt++;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no activity for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    empty_spans();
    for (int r = 0; r < ROWS; r++) begin
      snap_lft[r] = COLS[8:0];
      snap_rgt[r] = '0;
    end

    // Directed part: empty snapshot, edge rectangles, clamping and cap limits.
    queue_req(FUNC_REGIONS, 0, 0, 0, 0, 1);
    queue_req(FUNC_TOUCH, 0, 0, COLS, 1, 0);
    queue_req(FUNC_TOUCH, 511, 5, 511, 6, 127);
    queue_req(FUNC_TOUCH, 200, 10, 100, 12, 0);
    queue_req(FUNC_TOUCH, 0, 470, 1, 511, 0);
    queue_req(FUNC_TOUCH, 3, 500, 9, 511, 0);
    queue_req(FUNC_TOUCH, 3, 20, 9, 20, 0);
    queue_req(FUNC_TOUCH, 40, 30, 80, 35, 0);
    queue_req(FUNC_TOUCH, 10, 35, 60, 41, 0);
    queue_req(FUNC_TOUCH, 256, 100, COLS, 101, 0);
    queue_req(FUNC_OFFER, 0, 0, 0, 0, 0);
    queue_req(FUNC_REGIONS, 0, 0, 0, 0, 0);
    queue_req(FUNC_REGIONS, 0, 0, 0, 0, 127);
    queue_req(FUNC_REGIONS, 0, 0, 0, 0, 2);
    queue_req(FUNC_REGIONS, 0, 0, 0, 0, MaxRegions);
    queue_req(FUNC_CLEAR, 511, 511, 511, 511, 127);
    queue_req(FUNC_REGIONS, 0, 0, 0, 0, 5);
    queue_req(FUNC_OFFER, 0, 0, 0, 0, 0);
    queue_req(FUNC_REGIONS, 0, 0, 0, 0, 3);
    queue_req(FUNC_TOUCH, 0, 50, 0, 60, 0);
    queue_req(FUNC_TOUCH, 0, 0, COLS, ROWS, 0);
    queue_req(FUNC_OFFER, 0, 0, 0, 0, 0);
    queue_req(FUNC_REGIONS, 0, 0, 0, 0, MaxRegions);
    queue_drain();

    while (queued_cnt < TARGET_REQS) begin
      queue_frame();
      if ($urandom_range(0, 5) == 0) queue_drain();
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    wait (accepted_cnt == queued_cnt);
    while (region_q.size() != 0) @(posedge clk);
    repeat (ROWS + 8) @(posedge clk);

    $display("Requests: %0d touch, %0d clear, %0d offer, %0d regions.",
             touch_cnt, clear_cnt, offer_cnt, scan_cnt);
    $display("Results checked: %0d rectangles and %0d empty-snapshot replies.",
             region_cnt, empty_cnt);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/drst_pkg.sv
hdl/drst_ctrl.sv
hdl/drst_dp.sv
hdl/dirty_row_span_tracker_unit.sv
hdl/drst_chk.sv
tb/sv/tb.sv
